/* rtl/core/alis_pkg.sv */
// Shared constants, codes and controller/datapath link types for the array list block.
`default_nettype none

package alis_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = 7;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_READ   = 2'd2,
        CMD_SORT   = 2'd3
    } alis_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } alis_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INSERT,
        S_READ,
        S_SORT,
        S_DONE
    } alis_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_APPEND,
        DP_INS_INIT,
        DP_INS_STEP,
        DP_READ_ISSUE,
        DP_READ_CAPTURE,
        DP_SORT_INIT,
        DP_SORT_STEP
    } alis_dp_op_t;

    typedef struct packed {
        alis_dp_op_t  op;
        logic         st_en;
        alis_status_t st;
        logic         out_load;
    } alis_ctl_t;

    typedef struct packed {
        alis_cmd_t cmd;
        logic      full;
        logic      pos_gt_cnt;
        logic      pos_ge_cnt;
        logic      few;
        logic      ins_done;
        logic      sort_done;
    } alis_stat_t;

endpackage

`default_nettype wire

/* rtl/core/alis_if.sv */
// Valid/ready channel interfaces for command items and result items.
`default_nettype none

interface alis_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [alis_pkg::CMD_W-1:0]          command;
    logic signed [alis_pkg::DATA_W-1:0]  data;
    logic [alis_pkg::COUNT_W-1:0]        position;

    modport source (output valid, output command, output data, output position, input ready);
    modport sink   (input valid, input command, input data, input position, output ready);
endinterface

interface alis_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [alis_pkg::DATA_W-1:0]  value;
    logic [alis_pkg::COUNT_W-1:0]        count;
    logic [alis_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output value, output count, output status, input ready);
    modport sink   (input valid, input value, input count, input status, output ready);
endinterface

`default_nettype wire

/* rtl/core/array_list_insert_sort_top.sv */
// Top level of the bounded array list with insert, read and bubble sort.
//
//  channel  direction  payload                   transaction
//  cmd      in         command, data, position   valid && ready
//  res      out        value, count, status      valid && ready
//
// One command transaction at a time; ready is high only while idle.
// Sort of fewer than two entries leaves the list as it is; insert moves each word from
// the position up by one slot, and sort of n entries runs bubble passes of length n-1
// down to 1, all through the single RAM read and write ports.
// Reset clears the count; element storage is not cleared.
// A stalled result holds in the output register while the next command is accepted.
`default_nettype none

module array_list_insert_sort_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    alis_cmd_if.sink     cmd,
    alis_res_if.source   res
);

    alis_pkg::alis_ctl_t  ctl;
    alis_pkg::alis_stat_t stat;

    alis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    alis_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .stat     (stat),
        .command  (cmd.command),
        .data     (cmd.data),
        .position (cmd.position),
        .value    (res.value),
        .count    (res.count),
        .status   (res.status)
    );

endmodule

`default_nettype wire

/* rtl/core/alis_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module alis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/alis_datapath.sv */
// Datapath: item registers, element count, walk pointers and the element RAM.
`default_nettype none

module alis_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire alis_pkg::alis_ctl_t                 ctl,
    output alis_pkg::alis_stat_t                     stat,
    input  wire logic [alis_pkg::CMD_W-1:0]          command,
    input  wire logic signed [alis_pkg::DATA_W-1:0]  data,
    input  wire logic [alis_pkg::COUNT_W-1:0]        position,
    output logic signed [alis_pkg::DATA_W-1:0]       value,
    output logic [alis_pkg::COUNT_W-1:0]             count,
    output logic [alis_pkg::STATUS_W-1:0]            status
);

    localparam int AW = alis_pkg::ADDR_W;
    localparam int CW = alis_pkg::COUNT_W;
    localparam int DW = alis_pkg::DATA_W;

    // control state
    logic [CW-1:0]          count_reg, count_next;
    logic                   rv_reg, rv_next;

    // payload and walk registers
    alis_pkg::alis_cmd_t    cmd_reg, cmd_next;
    logic signed [DW-1:0]   data_reg, data_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic [AW-1:0]          wa_reg, wa_next;
    logic [AW-1:0]          last_reg, last_next;
    logic signed [DW-1:0]   cur_reg, cur_next;
    logic signed [DW-1:0]   value_reg, value_next;
    alis_pkg::alis_status_t st_reg, st_next;
    logic signed [DW-1:0]   out_value_reg, out_value_next;
    logic [CW-1:0]          out_count_reg, out_count_next;
    alis_pkg::alis_status_t out_st_reg, out_st_next;

    // RAM port
    logic                   we, re;
    logic [AW-1:0]          waddr, raddr;
    logic [DW-1:0]          wdata, rdata;
    logic signed [DW-1:0]   rword;

    logic                   ins_more, sort_more;
    logic [CW-1:0]          cnt_m1;

    assign rword     = $signed(rdata);
    assign ins_more  = (ptr_reg < count_reg);
    assign sort_more = (ptr_reg <= CW'(last_reg));
    assign cnt_m1    = count_reg - CW'(1);

    alis_ram #(
        .WIDTH (DW),
        .DEPTH (alis_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.full       = (count_reg == CW'(alis_pkg::CAPACITY));
        stat.pos_gt_cnt = (pos_reg > count_reg);
        stat.pos_ge_cnt = (pos_reg >= count_reg);
        stat.few        = (count_reg < CW'(2));
        stat.ins_done   = !ins_more && !rv_reg;
        stat.sort_done  = !sort_more && !rv_reg && (last_reg == AW'(1));
    end

    always_comb
    begin
        count_next     = count_reg;
        rv_next        = rv_reg;
        cmd_next       = cmd_reg;
        data_next      = data_reg;
        pos_next       = pos_reg;
        ptr_next       = ptr_reg;
        wa_next        = wa_reg;
        last_next      = last_reg;
        cur_next       = cur_reg;
        value_next     = value_reg;
        st_next        = ctl.st_en ? ctl.st : st_reg;
        out_value_next = out_value_reg;
        out_count_next = out_count_reg;
        out_st_next    = out_st_reg;
        we             = 1'b0;
        waddr          = count_reg[AW-1:0];
        wdata          = data_reg;
        re             = 1'b0;
        raddr          = ptr_reg[AW-1:0];

        case (ctl.op)
            alis_pkg::DP_LOAD:
            begin
                cmd_next   = alis_pkg::alis_cmd_t'(command);
                data_next  = data;
                pos_next   = position;
                value_next = '0;
            end
            alis_pkg::DP_APPEND:
            begin
                we         = 1'b1;
                waddr      = count_reg[AW-1:0];
                wdata      = data_reg;
                count_next = count_reg + CW'(1);
            end
            alis_pkg::DP_INS_INIT:
            begin
                ptr_next = pos_reg;
                cur_next = data_reg;
                rv_next  = 1'b0;
            end
            alis_pkg::DP_INS_STEP:
            begin
                // carry the displaced word one slot up per cycle
                if (ins_more)
                begin
                    re       = 1'b1;
                    raddr    = ptr_reg[AW-1:0];
                    ptr_next = ptr_reg + CW'(1);
                    wa_next  = ptr_reg[AW-1:0];
                end
                rv_next = ins_more;
                if (rv_reg)
                begin
                    we       = 1'b1;
                    waddr    = wa_reg;
                    wdata    = cur_reg;
                    cur_next = rword;
                end
                else if (!ins_more)
                begin
                    we         = 1'b1;
                    waddr      = count_reg[AW-1:0];
                    wdata      = cur_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            alis_pkg::DP_READ_ISSUE:
            begin
                re    = 1'b1;
                raddr = pos_reg[AW-1:0];
            end
            alis_pkg::DP_READ_CAPTURE:
            begin
                value_next = rword;
            end
            alis_pkg::DP_SORT_INIT:
            begin
                ptr_next  = '0;
                last_next = cnt_m1[AW-1:0];
                rv_next   = 1'b0;
            end
            alis_pkg::DP_SORT_STEP:
            begin
                if (sort_more)
                begin
                    re       = 1'b1;
                    raddr    = ptr_reg[AW-1:0];
                    ptr_next = ptr_reg + CW'(1);
                    wa_next  = ptr_reg[AW-1:0];
                end
                rv_next = sort_more;
                if (rv_reg)
                begin
                    // hold the larger word, write back the smaller one behind it
                    if (wa_reg == '0)
                    begin
                        cur_next = rword;
                    end
                    else if (cur_reg > rword)
                    begin
                        we    = 1'b1;
                        waddr = wa_reg - AW'(1);
                        wdata = rword;
                    end
                    else
                    begin
                        we       = 1'b1;
                        waddr    = wa_reg - AW'(1);
                        wdata    = cur_reg;
                        cur_next = rword;
                    end
                end
                else if (!sort_more)
                begin
                    // end of pass: park the largest word and shorten the walk
                    we        = 1'b1;
                    waddr     = last_reg;
                    wdata     = cur_reg;
                    last_next = last_reg - AW'(1);
                    ptr_next  = '0;
                end
            end
            default:
            begin
            end
        endcase

        if (ctl.out_load)
        begin
            out_value_next = value_reg;
            out_count_next = count_reg;
            out_st_next    = st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        data_reg      <= data_next;
        pos_reg       <= pos_next;
        ptr_reg       <= ptr_next;
        wa_reg        <= wa_next;
        last_reg      <= last_next;
        cur_reg       <= cur_next;
        value_reg     <= value_next;
        st_reg        <= st_next;
        out_value_reg <= out_value_next;
        out_count_reg <= out_count_next;
        out_st_reg    <= out_st_next;
    end

    assign value  = out_value_reg;
    assign count  = out_count_reg;
    assign status = out_st_reg;

endmodule

`default_nettype wire

/* rtl/core/alis_ctrl.sv */
// Controller: command sequencing state machine and the handshake on both channels.
`default_nettype none

module alis_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire alis_pkg::alis_stat_t  stat,
    output alis_pkg::alis_ctl_t        ctl
);

    alis_pkg::alis_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= alis_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        ctl.op         = alis_pkg::DP_NOP;
        ctl.st_en      = 1'b0;
        ctl.st         = alis_pkg::ST_OK;
        ctl.out_load   = 1'b0;

        case (state_reg)
            alis_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.op     = alis_pkg::DP_LOAD;
                    state_next = alis_pkg::S_DECODE;
                end
            end
            alis_pkg::S_DECODE:
            begin
                ctl.st_en  = 1'b1;
                state_next = alis_pkg::S_DONE;
                case (stat.cmd)
                    alis_pkg::CMD_APPEND:
                    begin
                        if (stat.full)
                        begin
                            ctl.st = alis_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctl.op = alis_pkg::DP_APPEND;
                        end
                    end
                    alis_pkg::CMD_INSERT:
                    begin
                        // range check wins over the full check
                        if (stat.pos_gt_cnt)
                        begin
                            ctl.st = alis_pkg::ST_RANGE;
                        end
                        else if (stat.full)
                        begin
                            ctl.st = alis_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctl.op     = alis_pkg::DP_INS_INIT;
                            state_next = alis_pkg::S_INSERT;
                        end
                    end
                    alis_pkg::CMD_READ:
                    begin
                        if (stat.pos_ge_cnt)
                        begin
                            ctl.st = alis_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ctl.op     = alis_pkg::DP_READ_ISSUE;
                            state_next = alis_pkg::S_READ;
                        end
                    end
                    default:
                    begin
                        if (!stat.few)
                        begin
                            ctl.op     = alis_pkg::DP_SORT_INIT;
                            state_next = alis_pkg::S_SORT;
                        end
                    end
                endcase
            end
            alis_pkg::S_INSERT:
            begin
                ctl.op = alis_pkg::DP_INS_STEP;
                if (stat.ins_done)
                begin
                    state_next = alis_pkg::S_DONE;
                end
            end
            alis_pkg::S_READ:
            begin
                ctl.op     = alis_pkg::DP_READ_CAPTURE;
                state_next = alis_pkg::S_DONE;
            end
            alis_pkg::S_SORT:
            begin
                ctl.op = alis_pkg::DP_SORT_STEP;
                if (stat.sort_done)
                begin
                    state_next = alis_pkg::S_DONE;
                end
            end
            alis_pkg::S_DONE:
            begin
                // advance only once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = alis_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = alis_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/alis_checker.sv */
// Port-level checker for the array list block and its bind to the top level.
`default_nettype none

module alis_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                res_valid,
    input wire logic                                res_ready,
    input wire logic signed [alis_pkg::DATA_W-1:0]  res_value,
    input wire logic [alis_pkg::COUNT_W-1:0]        res_count,
    input wire logic [alis_pkg::STATUS_W-1:0]       res_status
);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_count <= alis_pkg::COUNT_W'(alis_pkg::CAPACITY)))
        else $error("count above capacity");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_status == alis_pkg::ST_OK || res_status == alis_pkg::ST_FULL
                       || res_status == alis_pkg::ST_RANGE))
        else $error("undefined status code");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_status != alis_pkg::ST_OK) |-> (res_value == '0))
        else $error("nonzero value on failed command");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_status == alis_pkg::ST_FULL)
            |-> (res_count == alis_pkg::COUNT_W'(alis_pkg::CAPACITY)))
        else $error("full status below capacity");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_value)
                                       && $stable(res_count) && $stable(res_status)))
        else $error("stalled result changed");

endmodule

bind array_list_insert_sort_top alis_checker u_alis_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_value  (res.value),
    .res_count  (res.count),
    .res_status (res.status)
);

`default_nettype wire

/* sim/tb_top.sv */
// Testbench for the array list block: command stimulus, list predictor and result checks.
`timescale 1ns / 100ps

module tb_top;
    import alis_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 50;
    localparam int LIMIT_CYCLES = 8000000;
    localparam int MAX_REPORTS  = 60;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       count;
        alis_status_t             status;
    } list_result_t;

    logic clk;
    logic rst_n;

    alis_cmd_if cmd_ch ();
    alis_res_if res_ch ();

    array_list_insert_sort_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .res   (res_ch.source)
    );

    // predictor copy of the list
    logic signed [DATA_W-1:0] list_words [CAPACITY];
    int                       list_len;
    list_result_t             pending_results [$];

    int  error_count;
    int  burst_left;
    bit  sender_gaps_on;
    int  hold_cycles_left;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("tb_top: errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t mismatch %s: got 0x%08h want 0x%08h", $realtime, what, got, want);
    endtask

    function automatic list_result_t apply_list_command(input alis_cmd_t c,
                                                        input logic signed [DATA_W-1:0] d,
                                                        input logic [COUNT_W-1:0] p);
        list_result_t             r;
        logic signed [DATA_W-1:0] t;
        int                       pos;
        r.value  = '0;
        r.status = ST_OK;
        pos      = int'(p);
        case (c)
            CMD_APPEND:
            begin
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_words[list_len] = d;
                    list_len++;
                end
            end
            CMD_INSERT:
            begin
                if (pos > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = list_len; i > pos; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[pos] = d;
                    list_len++;
                end
            end
            CMD_READ:
            begin
                if (pos >= list_len)
                    r.status = ST_RANGE;
                else
                    r.value = list_words[pos];
            end
            default:
            begin
                for (int pass = 0; pass + 1 < list_len; pass++)
                    for (int j = 0; j + 1 < list_len - pass; j++)
                        if (list_words[j] > list_words[j + 1])
                        begin
                            t                 = list_words[j];
                            list_words[j]     = list_words[j + 1];
                            list_words[j + 1] = t;
                        end
            end
        endcase
        r.count = COUNT_W'(list_len);
        return r;
    endfunction

    // Hold valid until the transaction, then maybe open a gap before the next one.
    task automatic send_command(input alis_cmd_t c, input logic signed [DATA_W-1:0] d,
                                input logic [COUNT_W-1:0] p);
        int gap;
        @(negedge clk);
        cmd_ch.valid    = 1'b1;
        cmd_ch.command  = c;
        cmd_ch.data     = d;
        cmd_ch.position = p;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        pending_results.push_back(apply_list_command(c, d, p));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 7);
            gap        = sender_gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                cmd_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    function automatic logic signed [DATA_W-1:0] random_word();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $signed(32'($urandom_range(0, 15)) - 32'd8);
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic alis_cmd_t random_command(input int sort_weight);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < sort_weight)
            return CMD_SORT;
        else if (roll < sort_weight + 30)
            return CMD_APPEND;
        else if (roll < sort_weight + 60)
            return CMD_INSERT;
        else
            return CMD_READ;
    endfunction

    function automatic logic [COUNT_W-1:0] random_position(input alis_cmd_t c);
        if ($urandom_range(0, 99) < 12 || (c == CMD_READ && list_len == 0))
            return COUNT_W'($urandom_range(0, 127));
        else if (c == CMD_READ)
            return COUNT_W'($urandom_range(0, list_len - 1));
        else
            return COUNT_W'($urandom_range(0, list_len));
    endfunction

    task automatic run_random_commands(input int n_items, input int sort_weight);
        alis_cmd_t c;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 40 == 0)
                sender_gaps_on = $urandom_range(0, 3) != 0;
            c = random_command(sort_weight);
            send_command(c, random_word(), random_position(c));
        end
    endtask

    task automatic test_empty_list();
        send_command(CMD_READ, 32'sd5, 7'd0);
        send_command(CMD_READ, -32'sd1, 7'd127);
        send_command(CMD_SORT, 32'sd9, 7'd3);
        send_command(CMD_INSERT, 32'sd1, 7'd1);
        send_command(CMD_INSERT, 32'sd2, 7'd64);
    endtask

    task automatic test_insert_append();
        send_command(CMD_INSERT, 32'sh7FFF_FFFF, 7'd0);
        send_command(CMD_SORT, 32'sd0, 7'd0);
        send_command(CMD_APPEND, 32'sh8000_0000, 7'd127);
        send_command(CMD_APPEND, -32'sd1, 7'd55);
        send_command(CMD_INSERT, 32'sd0, 7'd1);
        send_command(CMD_INSERT, 32'sd1, 7'd4);
        send_command(CMD_INSERT, 32'sd3, 7'd6);
    endtask

    task automatic test_read_and_sort();
        for (int i = 0; i < 5; i++)
            send_command(CMD_READ, 32'sh5555_AAAA, COUNT_W'(i));
        send_command(CMD_READ, 32'sd0, 7'd5);
        send_command(CMD_SORT, -32'sd1, 7'd127);
        for (int i = 0; i < 5; i++)
            send_command(CMD_READ, 32'sd0, COUNT_W'(i));
    endtask

    // Keep the result side stalled so the block fills and drops its ready.
    task automatic test_backpressure();
        hold_cycles_left = 300;
        for (int i = 0; i < 10; i++)
            send_command((i % 2) ? CMD_READ : CMD_APPEND, random_word(),
                         COUNT_W'($urandom_range(0, list_len)));
    endtask

    task automatic test_full_list();
        while (list_len < CAPACITY)
            send_command(CMD_APPEND, random_word(), COUNT_W'($urandom_range(0, 127)));
        send_command(CMD_APPEND, 32'sd7, 7'd0);
        send_command(CMD_INSERT, 32'sd7, 7'd0);
        send_command(CMD_INSERT, 32'sd7, 7'd64);
        send_command(CMD_INSERT, 32'sd7, 7'd65);
        send_command(CMD_READ, 32'sd0, 7'd63);
        send_command(CMD_READ, 32'sd0, 7'd64);
        send_command(CMD_SORT, 32'sd0, 7'd0);
        send_command(CMD_READ, 32'sd0, 7'd0);
        send_command(CMD_READ, 32'sd0, 7'd63);
    endtask

    // Result side: stall pattern changes every stretch of cycles.
    initial
    begin
        int mode;
        int period;
        int duty;
        int cyc;
        res_ch.ready = 1'b0;
        mode   = 0;
        period = 4;
        duty   = 2;
        cyc    = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 150 == 0)
            begin
                mode   = $urandom_range(0, 3);
                period = $urandom_range(2, 9);
                duty   = $urandom_range(1, period - 1);
            end
            if (hold_cycles_left > 0)
            begin
                hold_cycles_left--;
                res_ch.ready = 1'b0;
            end
            else
                case (mode)
                    0:       res_ch.ready = 1'b1;
                    1:       res_ch.ready = $urandom_range(0, 1);
                    2:       res_ch.ready = $urandom_range(0, 9) != 0;
                    default: res_ch.ready = (cyc % period) < duty;
                endcase
        end
    end

    // Compare each result transaction with the oldest expected one.
    initial
    begin
        list_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with none expected", res_ch.value, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (res_ch.value !== want.value)
                        report_mismatch("value", res_ch.value, want.value);
                    if (res_ch.count !== want.count)
                        report_mismatch("count", 32'(res_ch.count), 32'(want.count));
                    if (res_ch.status !== want.status)
                        report_mismatch("status", 32'(res_ch.status), 32'(want.status));
                end
            end
        end
    end

    initial
    begin
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = CMD_APPEND;
        cmd_ch.data      = '0;
        cmd_ch.position  = '0;
        rst_n            = 1'b0;
        list_len         = 0;
        error_count      = 0;
        burst_left       = 0;
        sender_gaps_on   = 1'b1;
        hold_cycles_left = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_insert_append();
        test_read_and_sort();
        test_backpressure();
        run_random_commands(180, 6);
        test_full_list();
        run_random_commands(230, 8);

        @(negedge clk);
        cmd_ch.valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
